FILE: hdl/dps_pkg.sv
// Package for the dynamic priority scheduler.
// Holds the command codes, the slot and command types, and the per-tick slot update.
// No dependencies.
package dps_pkg;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Best candidate handed along the chain of slot cells
  typedef struct packed {
    logic       vld;
    logic [2:0] prio;
    logic [3:0] rtime;
  } cand_t;

  // Write command broadcast to every slot cell
  typedef struct packed {
    logic       load;
    logic       tick;
    logic [2:0] prio;
    logic [3:0] rtime;
  } upd_t;

  typedef struct packed {
    logic [2:0] prio;
    logic [3:0] rtime;
    logic       fin;
  } ent_t;

  // Slot contents after it has been picked by a tick
  function automatic ent_t tick_entry(logic [2:0] prio, logic [3:0] rtime);
    ent_t e;
    e.prio  = prio;
    e.rtime = rtime;
    e.fin   = 1'b0;
    if (rtime != 4'd0 && prio != 3'd0) begin
      e.rtime = rtime - 4'd1;
      e.prio  = prio - 3'd1;
    end else if (rtime != 4'd0) begin
      e.rtime = rtime - 4'd1;
    end else begin
      e.prio = 3'd0;
      e.fin  = 1'b1;
    end
    return e;
  endfunction

endpackage

FILE: hdl/dps_cell.sv
// One task slot of the scheduler: priority, remaining time and ready flag.
// Passes the better of its own entry and the incoming candidate to the next cell.
// Depends on dps_pkg.
module dps_cell #(
  parameter int unsigned IDX_W    = 3,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dps_pkg::upd_t        upd_i,
  input  logic [IDX_W-1:0]     sel_idx_i,
  input  dps_pkg::cand_t       cand_i,
  input  logic [IDX_W-1:0]     cand_idx_i,
  output dps_pkg::cand_t       cand_o,
  output logic [IDX_W-1:0]     cand_idx_o,
  output logic                 ready_o
);
  import dps_pkg::*;

  logic [2:0]       prio_q, prio_d;
  logic [3:0]       time_q, time_d;
  logic             rdy_q, rdy_d;
  cand_t            cand_q, cand_d;
  logic [IDX_W-1:0] cidx_q, cidx_d;
  logic             hit;
  ent_t             nxt;

  assign hit = (sel_idx_i == IDX_W'(CELL_IDX));
  assign nxt = tick_entry(prio_q, time_q);

  always_comb begin
    prio_d = prio_q;
    time_d = time_q;
    rdy_d  = rdy_q;
    if (hit && upd_i.load) begin
      prio_d = upd_i.prio;
      time_d = upd_i.rtime;
      rdy_d  = 1'b1;
    end else if (hit && upd_i.tick) begin
      prio_d = nxt.prio;
      time_d = nxt.rtime;
      rdy_d  = ~nxt.fin;
    end
  end

  // strictly greater wins, so lower indices keep ties
  always_comb begin
    cand_d = cand_i;
    cidx_d = cand_idx_i;
    if (rdy_q && (!cand_i.vld || prio_q > cand_i.prio)) begin
      cand_d.vld   = 1'b1;
      cand_d.prio  = prio_q;
      cand_d.rtime = time_q;
      cidx_d       = IDX_W'(CELL_IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_q <= '0;
      time_q <= '0;
      rdy_q  <= 1'b0;
      cand_q <= '0;
    end else begin
      prio_q <= prio_d;
      time_q <= time_d;
      rdy_q  <= rdy_d;
      cand_q <= cand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cidx_q <= cidx_d;
  end

  assign cand_o     = cand_q;
  assign cand_idx_o = cidx_q;
  assign ready_o    = rdy_q;

endmodule

FILE: hdl/dynamic_priority_scheduler_top.sv
// Dynamic priority scheduler: top level with sequencer and the chain of slot cells.
// Depends on dps_pkg and dps_cell.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one transaction per command:
//   a load writes priority and run time into one slot and marks it ready; a tick
//   picks the ready slot of highest priority (lowest index on ties) and ages it.
//   Output channel (out_valid_o/out_ready_i) returns one transaction per command.
//   A load goes from acceptance through the apply and done states to the
//   output register; a tick first passes a scan state, in which the
//   candidate sweeps one cell per cycle along the row of SLOTS cells.
//   One command is in flight at a time: the next is accepted only once the
//   sequencer is back in idle after the result write of the last one.
//   A result waits in the output register while the receiver stalls; the next
//   command is still accepted and worked on, and holds before its result
//   write until the output register is free.
//   Reset clears all slots to not ready with zero priority and time.
module dynamic_priority_scheduler_top #(
  parameter int unsigned SLOTS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_i,
  input  logic [2:0] slot_i,
  input  logic [2:0] priority_req_i,
  input  logic [3:0] run_time_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] chosen_slot_o,
  output logic [3:0] time_left_o,
  output logic [2:0] prio_now_o,
  output logic       finished_o,
  output logic       all_done_o
);
  import dps_pkg::*;

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_APPLY = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;

  logic             cmd_q;
  logic [2:0]       slot_q;
  logic [2:0]       prio_q;
  logic [3:0]       time_q;

  logic             win_vld_q;
  logic [IDX_W-1:0] win_idx_q;
  logic [2:0]       win_prio_q;
  logic [3:0]       win_time_q;

  logic [2:0]       res_slot_q;
  logic [3:0]       res_time_q;
  logic [2:0]       res_prio_q;
  logic             res_fin_q;

  logic             out_vld_q;
  logic [2:0]       out_slot_q;
  logic [3:0]       out_time_q;
  logic [2:0]       out_prio_q;
  logic             out_fin_q;
  logic             out_done_q;

  cand_t            chain [SLOTS+1];
  logic [IDX_W-1:0] chain_idx [SLOTS+1];
  logic [SLOTS-1:0] rdy;

  upd_t             upd;
  logic [IDX_W-1:0] sel_idx;
  logic             slot_ok;
  logic             in_fire;
  logic             out_free;
  ent_t             nxt;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_vld_q || out_ready_i;
  assign slot_ok    = ({4'd0, slot_q} < 7'(SLOTS));
  assign nxt        = tick_entry(win_prio_q, win_time_q);

  assign chain[0]     = '0;
  assign chain_idx[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    dps_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .upd_i      (upd),
      .sel_idx_i  (sel_idx),
      .cand_i     (chain[g]),
      .cand_idx_i (chain_idx[g]),
      .cand_o     (chain[g+1]),
      .cand_idx_o (chain_idx[g+1]),
      .ready_o    (rdy[g])
    );
  end

  always_comb begin
    upd.load  = (state_q == ST_APPLY) && (cmd_q == CMD_LOAD) && slot_ok;
    upd.tick  = (state_q == ST_APPLY) && (cmd_q == CMD_TICK) && win_vld_q;
    upd.prio  = prio_q;
    upd.rtime = time_q;
    sel_idx   = (cmd_q == CMD_LOAD) ? IDX_W'(slot_q) : win_idx_q;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_fire) begin
          state_d = (cmd_i == CMD_TICK) ? ST_SCAN : ST_APPLY;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == IDX_W'(SLOTS - 1)) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == ST_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= cmd_i;
      slot_q <= slot_i;
      prio_q <= priority_req_i;
      time_q <= run_time_i;
    end
    if (state_q == ST_SCAN && cnt_q == IDX_W'(SLOTS - 1)) begin
      win_vld_q  <= chain[SLOTS].vld;
      win_idx_q  <= chain_idx[SLOTS];
      win_prio_q <= chain[SLOTS].prio;
      win_time_q <= chain[SLOTS].rtime;
    end
    if (state_q == ST_APPLY) begin
      res_fin_q <= 1'b0;
      if (cmd_q == CMD_LOAD) begin
        res_slot_q <= slot_q;
        res_time_q <= slot_ok ? time_q : 4'd0;
        res_prio_q <= slot_ok ? prio_q : 3'd0;
      end else if (win_vld_q) begin
        res_slot_q <= 3'(win_idx_q);
        res_time_q <= nxt.rtime;
        res_prio_q <= nxt.prio;
        res_fin_q  <= nxt.fin;
      end else begin
        res_slot_q <= 3'd0;
        res_time_q <= 4'd0;
        res_prio_q <= 3'd0;
      end
    end
    if (state_q == ST_DONE && out_free) begin
      out_slot_q <= res_slot_q;
      out_time_q <= res_time_q;
      out_prio_q <= res_prio_q;
      out_fin_q  <= res_fin_q;
      out_done_q <= ~|rdy;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign chosen_slot_o = out_slot_q;
  assign time_left_o   = out_time_q;
  assign prio_now_o    = out_prio_q;
  assign finished_o    = out_fin_q;
  assign all_done_o    = out_done_q;

endmodule
